// ===== hw/rtl/smah_pkg.sv =====
// Package for the SIMD multiply-accumulate HI/LO core.
// Holds operation kinds and the queue entry type; no dependencies.
package smah_pkg;

  typedef enum logic [3:0] {
    KIND_MADD    = 4'd0,
    KIND_MADDU   = 4'd1,
    KIND_PHMADH  = 4'd2,
    KIND_PHMSBH  = 4'd3,
    KIND_PMADDH  = 4'd4,
    KIND_PMSUBH  = 4'd5,
    KIND_PMADDW  = 4'd6,
    KIND_PMADDUW = 4'd7,
    KIND_PMSUBW  = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_SCALAR,
    CLS_PAIR,
    CLS_LANE,
    CLS_WORD
  } cls_e;

  // Products form in the front; back part adds/subtracts into HI/LO.
  typedef struct packed {
    cls_e         cls;
    logic         sub;
    logic [255:0] prod32;  // eight 32-bit lane products
    logic [127:0] prod64;  // two 64-bit word products
  } op_t;

  localparam int unsigned FifoDepth = 2;

endpackage

// ===== hw/rtl/smah_if.sv =====
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface smah_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/smah_front.sv =====
// Front part: classifies the kind and forms all lane and word products.
// Depends on smah_pkg.
module smah_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      kind_i,
  input  logic [127:0]    rs_i,
  input  logic [127:0]    rt_i,
  output logic            op_valid_o,
  input  logic            op_ready_i,
  output smah_pkg::op_t   op_o
);
  smah_pkg::op_t op_d, op_q;
  logic          valid_q;

  assign in_ready_o = !valid_q || op_ready_i;
  assign op_valid_o = valid_q;
  assign op_o       = op_q;

  always_comb begin
    logic [32:0] x, y;
    op_d        = '0;
    op_d.cls    = smah_pkg::CLS_NONE;
    for (int i = 0; i < 8; i++) begin
      op_d.prod32[32*i +: 32] = 32'($signed(rs_i[16*i +: 16]) * $signed(rt_i[16*i +: 16]));
    end
    for (int d = 0; d < 2; d++) begin
      // 33-bit operands: top bit is the sign for signed kinds, zero otherwise
      x = {rs_i[64*d+31], rs_i[64*d +: 32]};
      y = {rt_i[64*d+31], rt_i[64*d +: 32]};
      if (kind_i == smah_pkg::KIND_MADDU || kind_i == smah_pkg::KIND_PMADDUW) begin
        x = {1'b0, rs_i[64*d +: 32]};
        y = {1'b0, rt_i[64*d +: 32]};
      end
      op_d.prod64[64*d +: 64] = 64'($signed(x) * $signed(y));
    end
    case (kind_i)
      smah_pkg::KIND_MADD, smah_pkg::KIND_MADDU: op_d.cls = smah_pkg::CLS_SCALAR;
      smah_pkg::KIND_PHMADH: op_d.cls = smah_pkg::CLS_PAIR;
      smah_pkg::KIND_PHMSBH: begin op_d.cls = smah_pkg::CLS_PAIR; op_d.sub = 1'b1; end
      smah_pkg::KIND_PMADDH: op_d.cls = smah_pkg::CLS_LANE;
      smah_pkg::KIND_PMSUBH: begin op_d.cls = smah_pkg::CLS_LANE; op_d.sub = 1'b1; end
      smah_pkg::KIND_PMADDW, smah_pkg::KIND_PMADDUW: op_d.cls = smah_pkg::CLS_WORD;
      smah_pkg::KIND_PMSUBW: begin op_d.cls = smah_pkg::CLS_WORD; op_d.sub = 1'b1; end
      default: op_d.cls = smah_pkg::CLS_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q <= op_d;
    end
  end
endmodule

// ===== hw/rtl/smah_fifo.sv =====
// Short queue between front and back parts.
// Depends on smah_pkg.
module smah_fifo #(
  parameter int unsigned Depth = smah_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  smah_pkg::op_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output smah_pkg::op_t rd_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  smah_pkg::op_t          mem_q [Depth];
  logic [AW-1:0]          wp_q, rp_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;
  logic                   wr, rd;

  assign wr_ready_o = cnt_q != ($clog2(Depth+1))'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ===== hw/rtl/smah_back.sv =====
// Back part: adds or subtracts products into HI/LO and registers the result.
// Depends on smah_pkg.
module smah_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            op_valid_i,
  output logic            op_ready_o,
  input  smah_pkg::op_t   op_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [127:0]    rd_o,
  output logic            rd_high_written_o,
  output logic [127:0]    lo_o,
  output logic [127:0]    hi_o
);
  logic [127:0] lo_q, hi_q, lo_d, hi_d, rd_d, rd_q;
  logic         wr_d, wr_q, valid_q, fire;
  logic [63:0]  acc, sum;
  logic [31:0]  r, old;

  assign op_ready_o        = !valid_q || res_ready_i;
  assign fire              = op_valid_i && op_ready_o;
  assign res_valid_o       = valid_q;
  assign rd_o              = rd_q;
  assign rd_high_written_o = wr_q;
  assign lo_o              = lo_q;
  assign hi_o              = hi_q;

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    rd_d = '0;
    wr_d = 1'b0;
    acc  = '0;
    sum  = '0;
    r    = '0;
    old  = '0;
    case (op_i.cls)
      smah_pkg::CLS_SCALAR, smah_pkg::CLS_WORD: begin
        for (int d = 0; d < 2; d++) begin
          if (op_i.cls == smah_pkg::CLS_WORD || d == 0) begin
            acc = {hi_q[64*d +: 32], lo_q[64*d +: 32]};
            sum = op_i.sub ? acc - op_i.prod64[64*d +: 64] : acc + op_i.prod64[64*d +: 64];
            lo_d[64*d +: 64] = {{32{sum[31]}}, sum[31:0]};
            hi_d[64*d +: 64] = {{32{sum[63]}}, sum[63:32]};
            rd_d[64*d +: 64] = sum;
          end
        end
        if (op_i.cls == smah_pkg::CLS_SCALAR) begin
          rd_d[63:0] = lo_d[63:0];
        end else begin
          wr_d = 1'b1;
        end
      end
      smah_pkg::CLS_PAIR: begin
        for (int p = 0; p < 4; p++) begin
          r = op_i.sub ? op_i.prod32[64*p+32 +: 32] - op_i.prod32[64*p +: 32]
                       : op_i.prod32[64*p+32 +: 32] + op_i.prod32[64*p +: 32];
          if (p[0]) hi_d[64*(p>>1) +: 32] = r;
          else      lo_d[64*(p>>1) +: 32] = r;
          rd_d[32*p +: 32] = r;
        end
        wr_d = 1'b1;
      end
      smah_pkg::CLS_LANE: begin
        for (int i = 0; i < 8; i++) begin
          old = i[1] ? hi_q[32*(i[0] | (i[2] << 1)) +: 32]
                     : lo_q[32*(i[0] | (i[2] << 1)) +: 32];
          r = op_i.sub ? old - op_i.prod32[32*i +: 32] : old + op_i.prod32[32*i +: 32];
          if (i[1]) hi_d[32*(i[0] | (i[2] << 1)) +: 32] = r;
          else      lo_d[32*(i[0] | (i[2] << 1)) +: 32] = r;
          if (!i[0]) rd_d[32*(i >> 1) +: 32] = r;
        end
        wr_d = 1'b1;
      end
      default: begin
        rd_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      if (op_ready_o) valid_q <= op_valid_i;
      if (fire) begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end
endmodule

// ===== hw/rtl/simd_multiply_accumulate_hilo_core.sv =====
// Top level of the SIMD multiply-accumulate HI/LO core.
// Depends on smah_pkg, smah_if, smah_front, smah_fifo, smah_back.
//
//  channel  dir  payload
//  in_if    in   kind, rs_low, rs_high, rt_low, rt_high
//  out_if   out  rd_low, rd_high, rd_high_written, lo_*, hi_*
//
// One transaction per cycle sustained while the output does not stall; each
// passes the product register, the queue and the accumulate/result register.
// The HI/LO add in the back stage sets the loop: one update per cycle, barring stalls.
// Reset clears HI, LO and all valid state. Output stalls fill the queue
// and then back-pressure the front; input idles do not affect results.
module simd_multiply_accumulate_hilo_core #(
  parameter int unsigned FifoDepth = smah_pkg::FifoDepth
) (
  input logic clk_i,
  input logic rst_ni,
  smah_if.sink   in_if,
  smah_if.source out_if
);
  // in_if.data  = {kind[3:0], rs_low, rs_high, rt_low, rt_high}
  // out_if.data = {rd_low, rd_high, rd_high_written, lo_low, lo_high, hi_low, hi_high}
  logic          f_valid, f_ready, b_valid, b_ready;
  smah_pkg::op_t f_op, b_op;
  logic [127:0]  rd, lo, hi;
  logic          rdw;

  smah_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .kind_i     (in_if.data[259:256]),
    .rs_i       ({in_if.data[191:128], in_if.data[255:192]}),
    .rt_i       ({in_if.data[63:0], in_if.data[127:64]}),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  smah_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_data_i (f_op),
    .rd_valid_o (b_valid), .rd_ready_i (b_ready), .rd_data_o (b_op)
  );

  smah_back u_back (
    .clk_i, .rst_ni,
    .op_valid_i (b_valid), .op_ready_o (b_ready), .op_i (b_op),
    .res_valid_o (out_if.valid), .res_ready_i (out_if.ready),
    .rd_o (rd), .rd_high_written_o (rdw), .lo_o (lo), .hi_o (hi)
  );

  assign out_if.data = {rd[63:0], rd[127:64], rdw, lo[63:0], lo[127:64],
                        hi[63:0], hi[127:64]};
endmodule

// ===== hw/rtl/smah_checker.sv =====
// Port-level checker for the multiply-accumulate core, bound to the top.
// Depends on smah_if.
module smah_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         out_valid,
  input logic         out_ready,
  input logic [384:0] out_data
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_no_out_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid)
    else $error("result right after reset");
  a_scalar_rdhi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data[256] |-> out_data[320:257] == '0)
    else $error("rd_high set without write flag");
  a_ready_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("valid in reset");
endmodule

bind simd_multiply_accumulate_hilo_core smah_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid (out_if.valid), .out_ready (out_if.ready), .out_data (out_if.data)
);

// ===== bench/tb_simd_multiply_accumulate_hilo_core.sv =====
// Self-checking bench for the SIMD multiply-accumulate HI/LO core.
// Depends on smah_pkg, smah_if and the RTL top level.
`timescale 1ns / 100ps

module tb_simd_multiply_accumulate_hilo_core;

  // Opcodes past the last defined kind: the core must leave HI/LO alone.
  localparam logic [3:0] KIND_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] KIND_UNUSED_LAST  = 4'd15;
  localparam int unsigned NumRandom = 1900;

  // Payload layouts, MSB first in port-list order.
  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] rs_low;
    logic [63:0] rs_high;
    logic [63:0] rt_low;
    logic [63:0] rt_high;
  } mac_op_t;

  typedef struct packed {
    logic [63:0] rd_low;
    logic [63:0] rd_high;
    logic        rd_high_written;
    logic [63:0] lo_low;
    logic [63:0] lo_high;
    logic [63:0] hi_low;
    logic [63:0] hi_high;
  } mac_result_t;

  logic clk_i;
  logic rst_ni;

  smah_if #(.W($bits(mac_op_t)))     in_ch ();
  smah_if #(.W($bits(mac_result_t))) out_ch ();

  simd_multiply_accumulate_hilo_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // 2 ns period
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Local copy of the accumulators, words 0..3 packed LSB first.
  logic [127:0] lo_words;
  logic [127:0] hi_words;

  mac_op_t     ops_to_send[$];
  mac_result_t results_due[$];
  int unsigned error_count;
  logic        in_took;
  int unsigned send_gap;
  int unsigned stall_left;
  logic        calm_mode;  // stretch with no idling on either side

  // Signed 16x16 lane product, truncated to 32 bits.
  function automatic logic [31:0] lane_product(logic [127:0] a, logic [127:0] b, int h);
    logic [31:0] x;
    logic [31:0] y;
    x = {{16{a[16*h+15]}}, a[16*h +: 16]};
    y = {{16{b[16*h+15]}}, b[16*h +: 16]};
    return x * y;
  endfunction

  // Full 64-bit product of word w of each source.
  function automatic logic [63:0] word_product(logic [127:0] a, logic [127:0] b, int w,
                                               logic sgn);
    logic [63:0] x;
    logic [63:0] y;
    x = {(sgn ? {32{a[32*w+31]}} : 32'd0), a[32*w +: 32]};
    y = {(sgn ? {32{b[32*w+31]}} : 32'd0), b[32*w +: 32]};
    return x * y;
  endfunction

  // Adds +/- product into pair {HI w, LO w}; entry of w/2 gets sign-extended halves.
  function automatic logic [63:0] pair_accumulate(logic [127:0] a, logic [127:0] b, int d,
                                                  logic sgn, logic sub);
    logic [63:0] acc;
    logic [63:0] prod;
    logic [63:0] sum;
    prod = word_product(a, b, 2 * d, sgn);
    acc  = {hi_words[64*d +: 32], lo_words[64*d +: 32]};
    sum  = sub ? acc - prod : acc + prod;
    lo_words[64*d +: 64] = {{32{sum[31]}}, sum[31:0]};
    hi_words[64*d +: 64] = {{32{sum[63]}}, sum[63:32]};
    return sum;
  endfunction

  // Advances the accumulators by one operation and returns the result.
  function automatic mac_result_t mac_update(mac_op_t op);
    mac_result_t res;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] rd;
    logic [31:0]  r;
    logic [31:0]  old;
    logic [31:0]  prod;
    int           w;
    a  = {op.rs_high, op.rs_low};
    b  = {op.rt_high, op.rt_low};
    rd = '0;
    res.rd_high_written = 1'b0;
    case (op.kind)
      smah_pkg::KIND_MADD, smah_pkg::KIND_MADDU: begin
        void'(pair_accumulate(a, b, 0, op.kind == smah_pkg::KIND_MADD, 1'b0));
        rd[63:0] = lo_words[63:0];
      end
      smah_pkg::KIND_PHMADH, smah_pkg::KIND_PHMSBH: begin
        for (int p = 0; p < 4; p++) begin
          if (op.kind == smah_pkg::KIND_PHMADH) begin
            r = lane_product(a, b, 2 * p + 1) + lane_product(a, b, 2 * p);
          end else begin
            r = lane_product(a, b, 2 * p + 1) - lane_product(a, b, 2 * p);
          end
          w = (p >> 1) * 2;
          if (p & 1) begin
            hi_words[32*w +: 32] = r;
          end else begin
            lo_words[32*w +: 32] = r;
          end
          rd[32*p +: 32] = r;
        end
        res.rd_high_written = 1'b1;
      end
      smah_pkg::KIND_PMADDH, smah_pkg::KIND_PMSUBH: begin
        // lane i: bit1 picks HI, bits {2,0} give the word
        for (int i = 0; i < 8; i++) begin
          w    = (i & 1) | ((i >> 2) << 1);
          prod = lane_product(a, b, i);
          old  = ((i >> 1) & 1) ? hi_words[32*w +: 32] : lo_words[32*w +: 32];
          r    = (op.kind == smah_pkg::KIND_PMADDH) ? old + prod : old - prod;
          if ((i >> 1) & 1) begin
            hi_words[32*w +: 32] = r;
          end else begin
            lo_words[32*w +: 32] = r;
          end
          if ((i & 1) == 0) rd[32*(i>>1) +: 32] = r;
        end
        res.rd_high_written = 1'b1;
      end
      smah_pkg::KIND_PMADDW, smah_pkg::KIND_PMADDUW, smah_pkg::KIND_PMSUBW: begin
        for (int d = 0; d < 2; d++) begin
          rd[64*d +: 64] = pair_accumulate(a, b, d, op.kind != smah_pkg::KIND_PMADDUW,
                                           op.kind == smah_pkg::KIND_PMSUBW);
        end
        res.rd_high_written = 1'b1;
      end
      default: ;  // unused opcode: nothing moves
    endcase
    res.rd_low  = rd[63:0];
    res.rd_high = rd[127:64];
    res.lo_low  = lo_words[63:0];
    res.lo_high = lo_words[127:64];
    res.hi_low  = hi_words[63:0];
    res.hi_high = hi_words[127:64];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
    error_count++;
  endtask

  // Mostly short gaps, a few long ones; none in calm stretches.
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_mode || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Operand half with a bias toward lane extremes.
  function automatic logic [63:0] operand_half();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '1;
      1: v = '0;
      2: begin
        for (int h = 0; h < 4; h++) begin
          case ($urandom_range(0, 4))
            0: v[16*h +: 16] = 16'h8000;
            1: v[16*h +: 16] = 16'h7fff;
            2: v[16*h +: 16] = 16'hffff;
            3: v[16*h +: 16] = 16'h0000;
            default: v[16*h +: 16] = 16'($urandom);
          endcase
        end
      end
      3: v = {($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff),
              ($urandom_range(0, 1) ? 32'h8000_0000 : 32'hffff_ffff)};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic mac_op_t make_op(logic [3:0] kind, logic [63:0] s, logic [63:0] t);
    mac_op_t op;
    op.kind    = kind;
    op.rs_low  = s;
    op.rs_high = s;
    op.rt_low  = t;
    op.rt_high = t;
    return op;
  endfunction

  // Input side: new transaction or gap at each falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_took) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          in_ch.valid  <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          in_ch.data   <= ops_to_send.pop_front();
          in_ch.valid  <= 1'b1;
          send_gap     <= idle_length();
          if ($urandom_range(0, 149) == 0) calm_mode <= !calm_mode;
        end else begin
          in_ch.valid  <= 1'b0;
        end
      end
      // Output side back-pressure.
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        out_ch.ready  <= 1'b0;
      end else begin
        out_ch.ready  <= 1'b1;
        stall_left    <= idle_length();
      end
    end
  end

  // Predict on input accept, check on output accept.
  always @(posedge clk_i) begin
    mac_result_t got;
    mac_result_t want;
    in_took <= in_ch.valid && in_ch.ready;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      results_due.push_back(mac_update(mac_op_t'(in_ch.data)));
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = mac_result_t'(out_ch.data);
      if (results_due.size() == 0) begin
        $display("%0t unexpected result transaction", $realtime);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (got.rd_low !== want.rd_low) report_mismatch("rd_low", got.rd_low, want.rd_low);
        if (got.rd_high !== want.rd_high) begin
          report_mismatch("rd_high", got.rd_high, want.rd_high);
        end
        if (got.rd_high_written !== want.rd_high_written) begin
          report_mismatch("rd_high_written", 64'(got.rd_high_written),
                          64'(want.rd_high_written));
        end
        if (got.lo_low !== want.lo_low) report_mismatch("lo_low", got.lo_low, want.lo_low);
        if (got.lo_high !== want.lo_high) begin
          report_mismatch("lo_high", got.lo_high, want.lo_high);
        end
        if (got.hi_low !== want.hi_low) report_mismatch("hi_low", got.hi_low, want.hi_low);
        if (got.hi_high !== want.hi_high) begin
          report_mismatch("hi_high", got.hi_high, want.hi_high);
        end
      end
    end
  end

  initial begin
    mac_op_t op;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    in_took      = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    calm_mode    = 1'b0;
    error_count  = 0;
    lo_words     = '0;
    hi_words     = '0;

    // Directed: every kind at the signed and unsigned extremes, four mixed cases,
    // then the first and last unused opcodes, which must hold HI/LO as they are.
    for (int k = smah_pkg::KIND_MADD; k <= smah_pkg::KIND_PMSUBW; k++) begin
      ops_to_send.push_back(make_op(4'(k), '1, '1));
      ops_to_send.push_back(make_op(4'(k), 64'h8000_8000_8000_8000,
                                    64'h8000_8000_8000_8000));
    end
    ops_to_send.push_back(make_op(smah_pkg::KIND_MADDU, 64'hffff_ffff_ffff_ffff,
                                  64'hffff_ffff));
    ops_to_send.push_back(make_op(smah_pkg::KIND_PMSUBW, 64'h7fff_ffff_8000_0000, '1));
    ops_to_send.push_back(make_op(smah_pkg::KIND_PHMSBH, 64'h7fff_8000_7fff_8000, '1));
    ops_to_send.push_back(make_op(smah_pkg::KIND_PMADDUW, 64'h0, 64'h0));
    ops_to_send.push_back(make_op(KIND_UNUSED_FIRST, '1, '1));
    ops_to_send.push_back(make_op(KIND_UNUSED_LAST, '1, '1));

    // Random: long accumulation chains, a sprinkle of unused opcodes.
    for (int n = 0; n < NumRandom; n++) begin
      op.kind    = ($urandom_range(0, 19) == 0)
                   ? 4'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST))
                   : 4'($urandom_range(smah_pkg::KIND_MADD, smah_pkg::KIND_PMSUBW));
      op.rs_low  = operand_half();
      op.rs_high = operand_half();
      op.rt_low  = operand_half();
      op.rt_high = operand_half();
      ops_to_send.push_back(op);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (ops_to_send.size() == 0 && !in_ch.valid && results_due.size() == 0);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hang guard, far past the slowest legal run.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
